@@ hw/rtl/hspd_pkg.sv @@
// Shared types and constants for the humidity sensor pulse decoder.
// No dependencies; imported by every module of the block.
package hspd_pkg;

  localparam int FRAME_BITS  = 40;
  localparam int BIT_IDX_W   = $clog2(FRAME_BITS + 1);
  localparam int TIMEOUT_W   = 16;
  localparam int SETTLE_W    = 8;
  localparam int STATUS_W    = 2;
  localparam int BYTE_W      = 8;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 24;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd32000;
  localparam logic [SETTLE_W-1:0]  SETTLE_RST  = 8'd50;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_TIMEOUT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SETTLE  = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd2;

  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [SETTLE_W-1:0]  settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   humidity;
    logic [BYTE_W-1:0]   temperature;
  } result_t;

  // Fifth byte must match the low byte of the sum of the first four.
  function automatic logic frame_ok(input frame_t f);
    logic [BYTE_W-1:0] sum;
    sum = f[39:32] + f[31:24] + f[23:16] + f[15:8];
    return sum == f[7:0];
  endfunction

endpackage

@@ hw/rtl/hspd_cfg_regs.sv @@
// Configuration registers of the pulse decoder: timeout and settle window.
// Depends on hspd_pkg.
module hspd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hspd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hspd_pkg::CFG_DATA_W-1:0] cfg_data,
  output hspd_pkg::cfg_t                  cfg
);
  import hspd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_addr)
        CFG_IDX_TIMEOUT: cfg_nxt.timeout_ticks = cfg_data[TIMEOUT_W-1:0];
        CFG_IDX_SETTLE:  cfg_nxt.settle_ticks  = cfg_data[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.settle_ticks  <= SETTLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/hspd_phase_fsm.sv @@
// Phase sequencer of the pulse decoder: times each line phase, builds the
// bit threshold, shifts in the frame and forms the result. Depends on hspd_pkg.
module hspd_phase_fsm #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              start_req,
  input  logic              line_level,
  input  hspd_pkg::cfg_t    cfg,
  output hspd_pkg::result_t res
);
  import hspd_pkg::*;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SETTLE    = 3'd1;
  localparam logic [2:0] PH_WAIT_LOW  = 3'd2;
  localparam logic [2:0] PH_RESP_LOW  = 3'd3;
  localparam logic [2:0] PH_RESP_HIGH = 3'd4;
  localparam logic [2:0] PH_BIT_LOW   = 3'd5;
  localparam logic [2:0] PH_BIT_HIGH  = 3'd6;

  localparam int CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
  localparam int SUM_W = COUNT_WIDTH + 1;

  logic [2:0]             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]       calib_r, calib_nxt;
  logic [BIT_IDX_W-1:0]   bidx_r, bidx_nxt;
  frame_t                 frame_r, frame_nxt;

  logic [COUNT_WIDTH-1:0] count_inc;
  logic [COUNT_WIDTH-1:0] count_sat;
  logic                   timed_out;
  logic                   settle_done;
  logic [COUNT_WIDTH-1:0] threshold;
  logic                   bit_val;
  frame_t                 frame_shift;
  logic [BIT_IDX_W-1:0]   bidx_inc;

  assign count_inc   = count_r + 1'b1;
  assign count_sat   = (&count_r) ? count_r : count_inc;
  assign timed_out   = CMP_W'(count_sat) >= CMP_W'(cfg.timeout_ticks);
  assign settle_done = CMP_W'(count_inc) >= CMP_W'(cfg.settle_ticks);
  assign threshold   = COUNT_WIDTH'(calib_r[SUM_W-1:2]);
  assign bit_val     = count_r >= threshold;
  assign frame_shift = {frame_r[FRAME_BITS-2:0], bit_val};
  assign bidx_inc    = bidx_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    calib_nxt = calib_r;
    bidx_nxt  = bidx_r;
    frame_nxt = frame_r;
    res       = '{valid: 1'b0, status: ST_OK, humidity: '0, temperature: '0};

    if (start_req) begin
      calib_nxt = '0;
      bidx_nxt  = '0;
      frame_nxt = '0;
      count_nxt = '0;
      phase_nxt = (cfg.settle_ticks == '0) ? PH_WAIT_LOW : PH_SETTLE;
    end else begin
      case (phase_r)
        PH_SETTLE: begin
          if (line_level || settle_done) begin
            phase_nxt = PH_WAIT_LOW;
            count_nxt = '0;
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_WAIT_LOW, PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
          // phase ends on the edge the phase waits for: high for odd codes,
          // low for even codes
          if (((phase_r == PH_WAIT_LOW || phase_r == PH_RESP_HIGH ||
                phase_r == PH_BIT_HIGH) && !line_level) ||
              ((phase_r == PH_RESP_LOW || phase_r == PH_BIT_LOW) && line_level)) begin
            count_nxt = '0;
            case (phase_r)
              PH_WAIT_LOW:  phase_nxt = PH_RESP_LOW;
              PH_RESP_LOW: begin
                calib_nxt = SUM_W'(count_r);
                phase_nxt = PH_RESP_HIGH;
              end
              PH_RESP_HIGH: begin
                calib_nxt = calib_r + SUM_W'(count_r);
                phase_nxt = PH_BIT_LOW;
              end
              PH_BIT_LOW:   phase_nxt = PH_BIT_HIGH;
              default: begin
                frame_nxt = frame_shift;
                bidx_nxt  = bidx_inc;
                if (bidx_inc >= BIT_IDX_W'(FRAME_BITS)) begin
                  phase_nxt = PH_IDLE;
                  res.valid = 1'b1;
                  if (frame_ok(frame_shift)) begin
                    res.status      = ST_OK;
                    res.humidity    = frame_shift[39:32];
                    res.temperature = frame_shift[23:16];
                  end else begin
                    res.status = ST_CHECKSUM;
                  end
                end else begin
                  phase_nxt = PH_BIT_LOW;
                end
              end
            endcase
          end else if (timed_out) begin
            phase_nxt  = PH_IDLE;
            count_nxt  = '0;
            res.valid  = 1'b1;
            res.status = ST_TIMEOUT;
          end else begin
            count_nxt = count_sat;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      calib_r <= '0;
      bidx_r  <= '0;
      frame_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      calib_r <= calib_nxt;
      bidx_r  <= bidx_nxt;
      frame_r <= frame_nxt;
    end
  end

endmodule

@@ hw/rtl/humidity_sensor_pulse_decoder.sv @@
// Humidity sensor pulse decoder: one sampled line level enters per beat, and
// the block times the sensor's response and 40 data pulses, then returns one
// result beat (status, humidity, temperature) when a read ends. Throughput is
// one input beat per clock when the output is not held; a sample is registered
// on entry, then processed by the phase sequencer once the output register can
// take a result, which is then registered there. The input side stalls only
// while a result sits in the output register and is not being taken.
// Depends on hspd_pkg, hspd_cfg_regs and hspd_phase_fsm.
module humidity_sensor_pulse_decoder #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hspd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hspd_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hspd_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] start_req, [1] line_level
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hspd_pkg::OUT_DATA_W-1:0] out_tdata   // [1:0] status, [9:2] humidity,
                                                      // [17:10] temperature
);
  import hspd_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_start_r;
  logic s1_level_r;
  logic advance;
  logic step;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [BYTE_W-1:0]     out_hum_r;
  logic [BYTE_W-1:0]     out_temp_r;

  hspd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hspd_phase_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .start_req  (s1_start_r),
    .line_level (s1_level_r),
    .cfg        (cfg),
    .res        (res)
  );

  // advance the sample stage only when the output register can take a result
  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_start_r <= in_tdata[0];
      s1_level_r <= in_tdata[1];
    end
    if (step && res.valid) begin
      out_status_r <= res.status;
      out_hum_r    <= res.humidity;
      out_temp_r   <= res.temperature;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_temp_r, out_hum_r, out_status_r};

endmodule
